// ===== rtl/gcva_pkg.sv =====
// Shared constants, codes, command type and mask test for the centre vote accumulator.
package gcva_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int POS_W         = 6;
    localparam int GRAD_W        = 16;
    localparam int WGT_W         = 8;
    localparam int SCORE_W       = 48;
    localparam int RAD_W         = 6;
    localparam int RAD_RESET     = 16;
    // |g|^2 <= 2^31 and weight < 2^8 bound every term below 2^39
    localparam int TERM_W        = 39;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_VOTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic              active;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [WGT_W-1:0]  wgt;
    } t_cmd;

    typedef struct packed {
        logic start;
        logic wgt_wr;
    } t_sweep_ctl;

    function automatic logic f_in_mask(input logic [8:0] x, input logic [8:0] y,
                                       input logic [8:0] half, input logic [RAD_W-1:0] r);
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic signed [19:0] sqx;
        logic signed [19:0] sqy;
        logic [20:0]        sum;
        logic [11:0]        rr;
        dx  = $signed({1'b0, x}) - $signed({1'b0, half});
        dy  = $signed({1'b0, y}) - $signed({1'b0, half});
        sqx = dx * dx;
        sqy = dy * dy;
        sum = 21'(unsigned'(sqx)) + 21'(unsigned'(sqy));
        rr  = 12'(r) * 12'(r);
        return sum <= 21'(rr);
    endfunction

endpackage

// ===== rtl/gcva_queue.sv =====
// Two-entry command queue between the front and back parts.
module gcva_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcva_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output gcva_pkg::t_cmd  o_cmd
);

    gcva_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// ===== rtl/gcva_front.sv =====
// Front part: accept input transactions and classify them into commands.
module gcva_front #(
    parameter int GRID_SIZE = gcva_pkg::GRID_SIZE_DEF
) (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic [gcva_pkg::POS_W-1:0]   i_col,
    input  logic [gcva_pkg::POS_W-1:0]   i_row,
    input  logic signed [gcva_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gcva_pkg::GRAD_W-1:0] i_grad_y,
    input  logic [gcva_pkg::WGT_W-1:0]   i_pixel_weight,
    input  logic [gcva_pkg::RAD_W-1:0]   i_radius,
    input  logic                         i_q_full,
    input  logic                         i_init,
    output logic                         o_push,
    output gcva_pkg::t_cmd               o_cmd
);

    logic in_grid;
    logic in_mask;
    logic active;

    assign in_grid = (9'(i_col) < 9'(GRID_SIZE)) && (9'(i_row) < 9'(GRID_SIZE));
    assign in_mask = gcva_pkg::f_in_mask(9'(i_col), 9'(i_row), 9'(GRID_SIZE / 2), i_radius);

    always_comb begin
        unique case (i_op)
            gcva_pkg::OP_VOTE:  active = in_grid && in_mask;
            gcva_pkg::OP_CLEAR: active = 1'b1;
            default:            active = in_grid;
        endcase
    end

    // hold off while the queue is full or the score clearing pass after reset runs
    assign o_ready = !i_q_full && !i_init;
    assign o_push  = i_valid && o_ready;

    assign o_cmd.op     = i_op;
    assign o_cmd.active = active;
    assign o_cmd.col    = i_col;
    assign o_cmd.row    = i_row;
    assign o_cmd.gx     = i_grad_x;
    assign o_cmd.gy     = i_grad_y;
    assign o_cmd.wgt    = i_pixel_weight;

endmodule

// ===== rtl/gcva_sweep.sv =====
// Vote sweep: weight memory, centre counter and pipelined term datapath with divider.
module gcva_sweep #(
    parameter int GRID_SIZE = gcva_pkg::GRID_SIZE_DEF,
    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcva_pkg::t_sweep_ctl          i_ctl,
    input  gcva_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_wr_idx,
    input  logic [gcva_pkg::RAD_W-1:0]    i_radius,
    output logic                          o_busy,
    output logic                          o_upd_valid,
    output logic [AW-1:0]                 o_upd_idx,
    output logic [gcva_pkg::TERM_W-1:0]   o_upd_term
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int NW    = CW + 17;
    localparam int MW    = 2 * CW + 1;
    localparam int QW    = gcva_pkg::TERM_W;
    localparam int DW    = 2 * NW + gcva_pkg::WGT_W;
    localparam int SW    = (DW > MW + QW) ? DW : MW + QW;

    logic [gcva_pkg::WGT_W-1:0] r_wmem [CELLS];
    logic [gcva_pkg::WGT_W-1:0] r_wdat;

    logic                r_run;
    logic [CW-1:0]       r_cx, r_cy, r_ox, r_oy;
    logic [AW-1:0]       r_idx;
    logic signed [15:0]  r_gx, r_gy;

    logic                s0_v;
    logic signed [CW:0]  s0_dx, s0_dy;

    logic                r1_v;
    logic signed [CW:0]  r1_dx, r1_dy;
    logic [AW-1:0]       r1_idx;
    logic signed [2*CW+1:0] s1_sqx, s1_sqy;

    logic                r2_v;
    logic signed [NW-1:0] r2_px, r2_py;
    logic [MW-1:0]       r2_mag, r3_mag, r4_mag;
    logic [gcva_pkg::WGT_W-1:0] r2_w, r3_w, r4_w;
    logic [AW-1:0]       r2_idx, r3_idx, r4_idx;
    logic signed [NW:0]  s2_num;

    logic                r3_v, r4_v;
    logic [NW-1:0]       r3_num;
    logic [2*NW-1:0]     r4_sq;

    logic [QW:0]         r_dv;
    logic [DW-1:0]       r_rem  [QW+1];
    logic [QW-1:0]       r_q    [QW+1];
    logic [MW-1:0]       r_dmag [QW+1];
    logic [AW-1:0]       r_didx [QW+1];
    logic [DW-1:0]       n_rem  [QW+1];
    logic [QW-1:0]       n_q    [QW+1];

    logic last;

    // weight store, written by load commands, read at the sweep counter
    always_ff @(posedge i_clk) begin
        if (i_ctl.wgt_wr) r_wmem[i_wr_idx] <= i_cmd.wgt;
        r_wdat <= r_wmem[r_idx];
    end

    assign last = (r_cx == CW'(GRID_SIZE - 1)) && (r_cy == CW'(GRID_SIZE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
        end else if (r_run && last) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_idx <= '0;
            r_ox  <= CW'(i_cmd.col);
            r_oy  <= CW'(i_cmd.row);
            r_gx  <= $signed(i_cmd.gx);
            r_gy  <= $signed(i_cmd.gy);
        end else if (r_run) begin
            r_idx <= r_idx + AW'(1);
            if (r_cx == CW'(GRID_SIZE - 1)) begin
                r_cx <= '0;
                r_cy <= r_cy + CW'(1);
            end else begin
                r_cx <= r_cx + CW'(1);
            end
        end
    end

    assign s0_v  = r_run && !((r_cx == r_ox) && (r_cy == r_oy))
                   && gcva_pkg::f_in_mask(9'(r_cx), 9'(r_cy), 9'(GRID_SIZE / 2), i_radius);
    assign s0_dx = $signed({1'b0, r_ox}) - $signed({1'b0, r_cx});
    assign s0_dy = $signed({1'b0, r_oy}) - $signed({1'b0, r_cy});

    assign s1_sqx = r1_dx * r1_dx;
    assign s1_sqy = r1_dy * r1_dy;
    assign s2_num = (NW+1)'(r2_px) + (NW+1)'(r2_py);

    // restoring division, one quotient bit per stage, highest bit first
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            logic [SW-1:0] dsh;
            logic          ge;
            dsh = SW'(r_dmag[s]) << (QW - 1 - s);
            ge  = SW'(r_rem[s]) >= dsh;
            n_rem[s+1] = ge ? DW'(SW'(r_rem[s]) - dsh) : r_rem[s];
            n_q[s+1]   = {r_q[s][QW-2:0], ge};
        end
        n_rem[0] = r_rem[0];
        n_q[0]   = r_q[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_dv <= '0;
        end else begin
            r1_v <= s0_v;
            r2_v <= r1_v;
            r3_v <= r2_v && !s2_num[NW] && (s2_num != '0);
            r4_v <= r3_v;
            r_dv <= {r_dv[QW-1:0], r4_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx  <= s0_dx;
        r1_dy  <= s0_dy;
        r1_idx <= r_idx;
        r2_px  <= r1_dx * r_gx;
        r2_py  <= r1_dy * r_gy;
        r2_mag <= MW'(unsigned'(s1_sqx)) + MW'(unsigned'(s1_sqy));
        r2_w   <= r_wdat;
        r2_idx <= r1_idx;
        r3_num <= s2_num[NW-1:0];
        r3_mag <= r2_mag;
        r3_w   <= r2_w;
        r3_idx <= r2_idx;
        r4_sq  <= r3_num * r3_num;
        r4_mag <= r3_mag;
        r4_w   <= r3_w;
        r4_idx <= r3_idx;
        r_rem[0]  <= r4_sq * r4_w;
        r_q[0]    <= '0;
        r_dmag[0] <= r4_mag;
        r_didx[0] <= r4_idx;
        for (int s = 1; s <= QW; s++) begin
            r_rem[s]  <= n_rem[s];
            r_q[s]    <= n_q[s];
            r_dmag[s] <= r_dmag[s-1];
            r_didx[s] <= r_didx[s-1];
        end
    end

    assign o_busy      = r_run || r1_v || r2_v || r3_v || r4_v || (|r_dv);
    assign o_upd_valid = r_dv[QW];
    assign o_upd_idx   = r_didx[QW];
    assign o_upd_term  = r_q[QW];

endmodule

// ===== rtl/gcva_back.sv =====
// Back part: command sequencer, score memory, clearing pass and result register.
module gcva_back #(
    parameter int GRID_SIZE = gcva_pkg::GRID_SIZE_DEF,
    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  gcva_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_init,
    output gcva_pkg::t_sweep_ctl           o_ctl,
    output logic [AW-1:0]                  o_head_idx,
    input  logic                           i_sweep_busy,
    input  logic                           i_upd_valid,
    input  logic [AW-1:0]                  i_upd_idx,
    input  logic [gcva_pkg::TERM_W-1:0]    i_upd_term,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gcva_pkg::SCORE_W-1:0]   o_score_value
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int SCW   = gcva_pkg::SCORE_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_VOTE  = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0]     r_state, n_state;
    logic           r_init;
    logic [AW-1:0]  r_clr_idx;
    logic           r_rd_active;
    logic           r_out_valid;
    logic [SCW-1:0] r_out;

    logic [SCW-1:0] r_smem [CELLS];
    logic [SCW-1:0] r_rdata;
    logic           r_wv;
    logic [AW-1:0]  r_widx;
    logic [gcva_pkg::TERM_W-1:0] r_wterm;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [SCW-1:0] wdata;
    logic [SCW:0]   sum;
    logic           clr_last;

    assign o_head_idx = AW'(AW'(CW'(i_cmd.row)) * AW'(GRID_SIZE)) + AW'(CW'(i_cmd.col));
    assign clr_last   = r_clr_idx == AW'(CELLS - 1);

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        o_ctl.start  = 1'b0;
        o_ctl.wgt_wr = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.op)
                        gcva_pkg::OP_LOAD: begin
                            o_pop        = 1'b1;
                            o_ctl.wgt_wr = i_cmd.active;
                        end
                        gcva_pkg::OP_VOTE: begin
                            o_pop       = 1'b1;
                            o_ctl.start = i_cmd.active;
                            if (i_cmd.active) n_state = ST_VOTE;
                        end
                        gcva_pkg::OP_READ: begin
                            if (!r_out_valid) begin
                                o_pop   = 1'b1;
                                n_state = ST_READ;
                            end
                        end
                        gcva_pkg::OP_CLEAR: begin
                            o_pop   = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        default: n_state = r_state;
                    endcase
                end
            end
            ST_VOTE:  if (!i_sweep_busy && !r_wv) n_state = ST_IDLE;
            ST_READ:  n_state = ST_IDLE;
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_init      <= 1'b1;
            r_clr_idx   <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= i_upd_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= clr_last ? '0 : r_clr_idx + AW'(1);
                if (clr_last) r_init <= 1'b0;
            end
            if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx  <= i_upd_idx;
        r_wterm <= i_upd_term;
        if (o_pop) r_rd_active <= i_cmd.active;
        if (r_state == ST_READ) r_out <= r_rd_active ? r_rdata : '0;
    end

    // read-add-write of one score per cycle; saturate at all ones
    assign sum   = (SCW+1)'(r_rdata) + (SCW+1)'(r_wterm);
    assign we    = (r_state == ST_CLEAR) || r_wv;
    assign waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_widx;
    assign wdata = (r_state == ST_CLEAR) ? '0 : (sum[SCW] ? '1 : sum[SCW-1:0]);
    assign raddr = (r_state == ST_IDLE) ? o_head_idx : i_upd_idx;

    always_ff @(posedge i_clk) begin
        if (we) r_smem[waddr] <= wdata;
        r_rdata <= r_smem[raddr];
    end

    assign o_init        = r_init;
    assign o_valid       = r_out_valid;
    assign o_score_value = r_out;

endmodule

// ===== rtl/gradient_center_vote_accumulator.sv =====
// Gradient centre vote accumulator: weight grid, score grid, gradient votes.
// A load writes one weight, a read moves one score to the result register, a clear zeroes all scores.
// A vote sweeps one centre per cycle through the sweep counter, then drains the
// 39-stage divider and the score read-add-write stage.
// Reset is synchronous, active low; after it a clearing pass zeroes the score memory
// while no input transaction is taken. Weights stay undefined.
module gradient_center_vote_accumulator #(
    parameter int GRID_SIZE = gcva_pkg::GRID_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [gcva_pkg::POS_W-1:0]          i_col,
    input  logic [gcva_pkg::POS_W-1:0]          i_row,
    input  logic signed [gcva_pkg::GRAD_W-1:0]  i_grad_x,
    input  logic signed [gcva_pkg::GRAD_W-1:0]  i_grad_y,
    input  logic [gcva_pkg::WGT_W-1:0]          i_pixel_weight,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gcva_pkg::SCORE_W-1:0]        o_score_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gcva_pkg::RAD_W-1:0]          i_mask_radius
);

    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

    logic [gcva_pkg::RAD_W-1:0] r_radius;
    logic                 push, pop, q_full, q_empty, init;
    gcva_pkg::t_cmd       in_cmd, head_cmd;
    gcva_pkg::t_sweep_ctl ctl;
    logic [AW-1:0]        head_idx;
    logic                 sweep_busy, upd_valid;
    logic [AW-1:0]        upd_idx;
    logic [gcva_pkg::TERM_W-1:0] upd_term;

    // the mask radius register takes a transaction on every cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcva_pkg::RAD_W'(gcva_pkg::RAD_RESET);
        end else if (i_cfg_valid) begin
            r_radius <= i_mask_radius;
        end
    end

    // front: classify each transaction (inside the grid, and for votes origin inside the mask)
    gcva_front #(.GRID_SIZE(GRID_SIZE)) u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_grad_x       (i_grad_x),
        .i_grad_y       (i_grad_y),
        .i_pixel_weight (i_pixel_weight),
        .i_radius       (r_radius),
        .i_q_full       (q_full),
        .i_init         (init),
        .o_push         (push),
        .o_cmd          (in_cmd)
    );

    // queue lets the front keep taking transactions while a vote sweeps
    gcva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (in_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // back: sequence commands, own the scores and the result register
    gcva_back #(.GRID_SIZE(GRID_SIZE)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_init        (init),
        .o_ctl         (ctl),
        .o_head_idx    (head_idx),
        .i_sweep_busy  (sweep_busy),
        .i_upd_valid   (upd_valid),
        .i_upd_idx     (upd_idx),
        .i_upd_term    (upd_term),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_score_value (o_score_value)
    );

    // sweep: one centre per cycle, terms emerge after the divider
    gcva_sweep #(.GRID_SIZE(GRID_SIZE)) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cmd       (head_cmd),
        .i_wr_idx    (head_idx),
        .i_radius    (r_radius),
        .o_busy      (sweep_busy),
        .o_upd_valid (upd_valid),
        .o_upd_idx   (upd_idx),
        .o_upd_term  (upd_term)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full)) else $error("command pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_empty)) else $error("command popped from an empty queue");
    a_no_pop_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && init)) else $error("command taken during the clearing pass");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |-> !sweep_busy) else $error("vote started while the sweep is busy");
`endif

endmodule
